/* design/pisq_pkg.sv */
// pisq_pkg: shared types and fixed widths for the product / square-root block
// used by pisq_mul, pisq_step and product_isqrt_128; no dependencies
package pisq_pkg;

    localparam int FIELD_W = 64;
    localparam int HALF_W  = 32;
    localparam int PROD_W  = 2 * FIELD_W;

    typedef struct packed {
        logic [FIELD_W-1:0] factor_a;
        logic [FIELD_W-1:0] factor_b;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] product_high;
        logic [FIELD_W-1:0] product_low;
        logic [FIELD_W-1:0] root;
    } t_out_item;

endpackage

/* design/pisq_mul.sv */
// pisq_mul: two-stage 64x64 unsigned multiplier built from four 32x32 products
// depends on pisq_pkg for field widths
module pisq_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [pisq_pkg::FIELD_W-1:0]   i_a,
    input  logic [pisq_pkg::FIELD_W-1:0]   i_b,
    output logic                           o_vld,
    output logic [pisq_pkg::PROD_W-1:0]    o_prod
);

    localparam int HW = pisq_pkg::HALF_W;
    localparam int FW = pisq_pkg::FIELD_W;
    localparam int PW = pisq_pkg::PROD_W;

    logic [FW-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [FW-1:0] n_ll, n_lh, n_hl, n_hh;
    logic          r_pp_vld;
    logic [PW-1:0] r_prod, n_prod;
    logic          r_prod_vld;

    always_comb begin
        n_ll = FW'(i_a[HW-1:0])  * FW'(i_b[HW-1:0]);
        n_lh = FW'(i_a[HW-1:0])  * FW'(i_b[FW-1:HW]);
        n_hl = FW'(i_a[FW-1:HW]) * FW'(i_b[HW-1:0]);
        n_hh = FW'(i_a[FW-1:HW]) * FW'(i_b[FW-1:HW]);
    end

    // cross terms are aligned at the half-word boundary
    always_comb begin
        n_prod = {r_hh, r_ll}
               + (PW'(r_lh) << HW)
               + (PW'(r_hl) << HW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else if (i_en) begin
            r_pp_vld   <= i_vld;
            r_prod_vld <= r_pp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll   <= n_ll;
            r_lh   <= n_lh;
            r_hl   <= n_hl;
            r_hh   <= n_hh;
            r_prod <= n_prod;
        end
    end

    assign o_vld  = r_prod_vld;
    assign o_prod = r_prod;

endmodule

/* design/pisq_step.sv */
// pisq_step: one registered bit of the digit-by-digit square root
// keeps remainder = product - root^2 and carries the product along; uses pisq_pkg
module pisq_step #(
    parameter int STEP   = 0,
    parameter int ROOT_W = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [2*ROOT_W-1:0]            i_rem,
    input  logic [ROOT_W-1:0]              i_root,
    input  logic [pisq_pkg::PROD_W-1:0]    i_prod,
    output logic                           o_vld,
    output logic [2*ROOT_W-1:0]            o_rem,
    output logic [ROOT_W-1:0]              o_root,
    output logic [pisq_pkg::PROD_W-1:0]    o_prod
);

    localparam int RW = 2 * ROOT_W;

    logic [RW-1:0]               w_delta;
    logic                        w_take;
    logic                        r_vld;
    logic [RW-1:0]               r_rem, n_rem;
    logic [ROOT_W-1:0]           r_root, n_root;
    logic [pisq_pkg::PROD_W-1:0] r_prod;

    // (root + 2^s)^2 - root^2 = root * 2^(s+1) + 2^(2s); root has no bits at or below s
    always_comb begin
        w_delta = (RW'(i_root) << (STEP + 1)) | (RW'(1) << (2 * STEP));
        w_take  = (i_rem >= w_delta);
        n_rem   = w_take ? (i_rem - w_delta) : i_rem;
        n_root  = w_take ? (i_root | (ROOT_W'(1) << STEP)) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_prod <= i_prod;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_prod = r_prod;

endmodule

/* design/product_isqrt_128.sv */
// product_isqrt_128: full product of two unsigned factors and its floor square root
// depends on pisq_pkg, pisq_mul and pisq_step
//
// Usage:
//   Input channel: i_valid / i_data (factor_a, factor_b) / o_stall. A transfer
//   happens at a clock edge with i_valid high and o_stall low. Factor bits at and
//   above OPERAND_WIDTH are ignored.
//   Output channel: o_valid / o_data (product_high, product_low, root) / i_stall.
//   Exactly one result per input item, in order.
//   Pipeline: from input transfer to o_valid an item passes one input register,
//   two multiplier stages, then one pipeline stage per root bit, each a single
//   remainder compare and subtract.
//   Throughput: one item per cycle while no stall freezes the pipeline; the pipeline is fully occupied at steady state.
//   Stall: while i_stall holds a valid result, the whole pipeline freezes and
//   o_stall goes high; o_data holds. Empty slots do not block new transfers.
//   Reset: i_rst_n low for one edge clears all valid bits; no results are
//   produced from items in flight at reset.
module product_isqrt_128 #(
    parameter int OPERAND_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  pisq_pkg::t_in_item    i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output pisq_pkg::t_out_item   o_data,
    input  logic                  i_stall
);

    localparam int FW = pisq_pkg::FIELD_W;
    localparam int PW = pisq_pkg::PROD_W;
    localparam int W  = OPERAND_WIDTH;
    localparam int RW = 2 * OPERAND_WIDTH;
    localparam logic [FW-1:0] OPW_MASK =
        (W >= FW) ? {FW{1'b1}} : ((FW'(1) << W) - FW'(1));

    logic          w_en;
    logic          r_in_vld;
    logic [FW-1:0] r_a, r_b;
    logic          w_mul_vld;
    logic [PW-1:0] w_mul_prod;

    logic          w_vld  [0:W];
    logic [RW-1:0] w_rem  [0:W];
    logic [W-1:0]  w_root [0:W];
    logic [PW-1:0] w_prod [0:W];

    // pipeline moves unless the output holds a result the receiver refuses
    assign w_en    = !(w_vld[W] && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= i_data.factor_a & OPW_MASK;
            r_b <= i_data.factor_b & OPW_MASK;
        end
    end

    pisq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_in_vld),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_vld   (w_mul_vld),
        .o_prod  (w_mul_prod)
    );

    // masked product fits in 2*W bits
    assign w_vld[0]  = w_mul_vld;
    assign w_rem[0]  = w_mul_prod[RW-1:0];
    assign w_root[0] = '0;
    assign w_prod[0] = w_mul_prod;

    for (genvar g = 0; g < W; g++) begin : g_step
        pisq_step #(
            .STEP   (W - 1 - g),
            .ROOT_W (W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .i_prod  (w_prod[g]),
            .o_vld   (w_vld[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1]),
            .o_prod  (w_prod[g+1])
        );
    end

    assign o_valid             = w_vld[W];
    assign o_data.product_high = w_prod[W][PW-1:FW];
    assign o_data.product_low  = w_prod[W][FW-1:0];
    assign o_data.root         = FW'(w_root[W]);

    // stall is only raised against a result that is actually waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result waiting");

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a frozen pipeline keeps its entry stage and its result
    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_in_vld) && $stable(w_mul_vld) && $stable(w_root[W])))
        else $error("pipeline moved while stalled");

    // root is zero exactly when the product is zero
    a_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.root == '0) ==
                     ((o_data.product_high == '0) && (o_data.product_low == '0))))
        else $error("root and product disagree on zero");

endmodule
